FILE: src/bcfm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Battery cell fault monitor package
// Shared types, register indexes, thresholds and flag positions.
// ----------------------------------------------------------------------------
package bcfm_pkg;

   localparam int SAMPLE_W = 17;
   localparam int CELL_W   = 16;
   localparam int PACK_W   = 23;
   localparam int TEMP_W   = 8;
   localparam int FLAG_W   = 8;
   localparam int CSR_W    = 23;
   localparam int CSR_IDX_W = 3;

   typedef enum logic [1:0] {
      OP_VOLT   = 2'd0,
      OP_TEMP   = 2'd1,
      OP_FINISH = 2'd2
   } op_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_PACK_HIGH_FAULT = 3'd0,
      CSR_PACK_LOW_FAULT  = 3'd1,
      CSR_CELL_HIGH_FAULT = 3'd2,
      CSR_CELL_LOW_FAULT  = 3'd3,
      CSR_TEMP_HIGH_FAULT = 3'd4,
      CSR_IMBALANCE_FAULT = 3'd5,
      CSR_CELL_HIGH_WARN  = 3'd6,
      CSR_CELL_LOW_WARN   = 3'd7
   } csr_index_type;

   localparam logic [PACK_W-1:0]        PACK_HIGH_FAULT_RST = 23'd410000;
   localparam logic [PACK_W-1:0]        PACK_LOW_FAULT_RST  = 23'd288000;
   localparam logic [CELL_W-1:0]        CELL_HIGH_FAULT_RST = 16'd43000;
   localparam logic [CELL_W-1:0]        CELL_LOW_FAULT_RST  = 16'd30000;
   localparam logic signed [TEMP_W-1:0] TEMP_HIGH_FAULT_RST = 8'sd60;
   localparam logic [CELL_W-1:0]        IMBALANCE_FAULT_RST = 16'd5000;
   localparam logic [CELL_W-1:0]        CELL_HIGH_WARN_RST  = 16'd42500;
   localparam logic [CELL_W-1:0]        CELL_LOW_WARN_RST   = 16'd32000;

   localparam logic [PACK_W-1:0]        PACK_HIGH_WARN = 23'd408500;
   localparam logic [PACK_W-1:0]        PACK_LOW_WARN  = 23'd300000;
   localparam logic signed [TEMP_W-1:0] TEMP_HIGH_WARN = 8'sd55;
   localparam logic signed [TEMP_W-1:0] TEMP_LOW_WARN  = 8'sd0;
   localparam logic [CELL_W-1:0]        IMBALANCE_WARN = 16'd1000;

   localparam logic signed [SAMPLE_W-1:0] TEMP_SAT_HIGH = 17'sd127;
   localparam logic signed [SAMPLE_W-1:0] TEMP_SAT_LOW  = -17'sd128;

   localparam logic [FLAG_W-1:0] BALANCE_FLAG = 8'b1000_0000;

   localparam int FLAG_PACK_HIGH = 7;
   localparam int FLAG_PACK_LOW  = 6;
   localparam int FLAG_CELL_LOW  = 5;
   localparam int FLAG_CELL_HIGH = 4;
   localparam int FLAG_TEMP_HIGH = 3;
   localparam int FLAG_FAULT_IMB = 2;
   localparam int FLAG_TEMP_LOW  = 2;
   localparam int FLAG_WARN_IMB  = 1;

   typedef struct packed {
      logic [PACK_W-1:0]        pack_high_fault;
      logic [PACK_W-1:0]        pack_low_fault;
      logic [CELL_W-1:0]        cell_high_fault;
      logic [CELL_W-1:0]        cell_low_fault;
      logic signed [TEMP_W-1:0] temp_high_fault;
      logic [CELL_W-1:0]        imbalance_fault;
      logic [CELL_W-1:0]        cell_high_warn;
      logic [CELL_W-1:0]        cell_low_warn;
   } limits_type;

   typedef struct packed {
      logic [CELL_W-1:0]        volt_high;
      logic [CELL_W-1:0]        volt_low;
      logic signed [TEMP_W-1:0] heat_high;
      logic signed [TEMP_W-1:0] heat_low;
      logic [PACK_W-1:0]        volt_total;
      logic                     volt_seen;
      logic                     heat_seen;
   } scan_state_type;

   typedef struct packed {
      logic [1:0]                 operation;
      logic signed [SAMPLE_W-1:0] sample_value;
      logic                       balance_active;
   } req_item_type;

endpackage

FILE: src/bcfm_req_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Battery cell fault monitor request channel
// Valid/ready channel carrying one sample or finish transaction.
// ----------------------------------------------------------------------------
interface bcfm_req_if;
   logic                valid;
   logic                ready;
   logic [1:0]          operation;
   logic signed [16:0]  sample_value;
   logic                balance_active;

   modport source (output valid, output operation, output sample_value,
                   output balance_active, input ready);
   modport sink   (input valid, input operation, input sample_value,
                   input balance_active, output ready);
endinterface

FILE: src/bcfm_rsp_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Battery cell fault monitor response channel
// Valid/ready channel carrying one scan summary transaction.
// ----------------------------------------------------------------------------
interface bcfm_rsp_if;
   logic               valid;
   logic               ready;
   logic [7:0]         fault_flags;
   logic [7:0]         warning_flags;
   logic [7:0]         state_flags;
   logic [22:0]        pack_sum;
   logic [15:0]        cell_max;
   logic [15:0]        cell_min;
   logic signed [7:0]  temp_max;
   logic signed [7:0]  temp_min;

   modport source (output valid, output fault_flags, output warning_flags,
                   output state_flags, output pack_sum, output cell_max,
                   output cell_min, output temp_max, output temp_min,
                   input ready);
   modport sink   (input valid, input fault_flags, input warning_flags,
                   input state_flags, input pack_sum, input cell_max,
                   input cell_min, input temp_max, input temp_min,
                   output ready);
endinterface

FILE: src/bcfm_eval.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Battery cell fault monitor threshold evaluation
// Compares the scan summary against fault and warning thresholds.
// ----------------------------------------------------------------------------
module bcfm_eval
   import bcfm_pkg::*;
(
   input  scan_state_type    scan,
   input  limits_type        limits,
   output logic [FLAG_W-1:0] fault_flags,
   output logic [FLAG_W-1:0] warning_flags
);

   logic [CELL_W-1:0] spread;

   assign spread = scan.volt_high - scan.volt_low;

   always_comb begin
      fault_flags   = '0;
      warning_flags = '0;

      fault_flags[FLAG_PACK_HIGH] = scan.volt_total >= limits.pack_high_fault;
      fault_flags[FLAG_PACK_LOW]  = scan.volt_total <= limits.pack_low_fault;
      fault_flags[FLAG_CELL_LOW]  = scan.volt_low <= limits.cell_low_fault;
      fault_flags[FLAG_CELL_HIGH] = scan.volt_high >= limits.cell_high_fault;
      fault_flags[FLAG_TEMP_HIGH] = $signed(scan.heat_high) >=
                                    $signed(limits.temp_high_fault);
      fault_flags[FLAG_FAULT_IMB] = spread >= limits.imbalance_fault;

      warning_flags[FLAG_PACK_HIGH] = scan.volt_total >= PACK_HIGH_WARN;
      warning_flags[FLAG_PACK_LOW]  = scan.volt_total <= PACK_LOW_WARN;
      warning_flags[FLAG_CELL_LOW]  = scan.volt_low <= limits.cell_low_warn;
      warning_flags[FLAG_CELL_HIGH] = scan.volt_high >= limits.cell_high_warn;
      warning_flags[FLAG_TEMP_HIGH] = $signed(scan.heat_high) >= TEMP_HIGH_WARN;
      warning_flags[FLAG_TEMP_LOW]  = $signed(scan.heat_low) <= TEMP_LOW_WARN;
      warning_flags[FLAG_WARN_IMB]  = spread >= IMBALANCE_WARN;
   end

endmodule

FILE: src/battery_cell_fault_monitor_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Battery cell fault monitor
// Tracks cell voltage and temperature extremes over a scan and reports
// fault, warning and state flags with the summary on each finish.
// ----------------------------------------------------------------------------
// Usage:
//   req_if carries cell voltage samples, temperature samples and finish
//   transactions; rsp_if returns one summary transaction per finish.
//   Samples produce no response; an unused operation code is dropped.
//   Each request is captured in an input register; a sample is processed
//   next against the running scan registers, and a finish, once the
//   response register is free, loads it and clears the scan, passing the
//   input then the response register. One transaction per cycle is
//   accepted unless a finish is held. When the receiver stalls, samples
//   keep flowing; a finish waits in the input register until the response
//   register is free, which holds off req_if.ready for that time only.
//   csr_* writes one threshold register per cycle, no read-back; write only
//   while the block is idle.
//   Reset (synchronous, active high) restores default thresholds, clears
//   the scan and empties both registers.
// ----------------------------------------------------------------------------
module battery_cell_fault_monitor_unit
   import bcfm_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_write_enable,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CSR_W-1:0]     csr_write_data,
   bcfm_req_if.sink             req_if,
   bcfm_rsp_if.source           rsp_if
);

   limits_type     limits_ff;
   scan_state_type scan_ff, scan_in;
   req_item_type   item_ff;
   logic           item_valid_ff;
   logic           rsp_valid_ff;
   logic [FLAG_W-1:0] fault_flags, warning_flags;

   logic is_finish, out_free, advance, req_accept;
   logic [CELL_W-1:0]        volt_value;
   logic signed [TEMP_W-1:0] temp_value;
   logic [PACK_W:0]          sum_wide;
   logic [PACK_W-1:0]        sum_sat;

   assign is_finish  = op_type'(item_ff.operation) == OP_FINISH;
   assign out_free   = !rsp_valid_ff || rsp_if.ready;
   assign advance    = item_valid_ff && (!is_finish || out_free);
   assign req_if.ready = !item_valid_ff || advance;
   assign req_accept = req_if.valid && req_if.ready;

   // configuration
   always_ff @(posedge clock) begin
      if (reset) begin
         limits_ff.pack_high_fault <= PACK_HIGH_FAULT_RST;
         limits_ff.pack_low_fault  <= PACK_LOW_FAULT_RST;
         limits_ff.cell_high_fault <= CELL_HIGH_FAULT_RST;
         limits_ff.cell_low_fault  <= CELL_LOW_FAULT_RST;
         limits_ff.temp_high_fault <= TEMP_HIGH_FAULT_RST;
         limits_ff.imbalance_fault <= IMBALANCE_FAULT_RST;
         limits_ff.cell_high_warn  <= CELL_HIGH_WARN_RST;
         limits_ff.cell_low_warn   <= CELL_LOW_WARN_RST;
      end else if (csr_write_enable) begin
         unique case (csr_index_type'(csr_index))
            CSR_PACK_HIGH_FAULT: limits_ff.pack_high_fault <= csr_write_data;
            CSR_PACK_LOW_FAULT:  limits_ff.pack_low_fault  <= csr_write_data;
            CSR_CELL_HIGH_FAULT: limits_ff.cell_high_fault <= csr_write_data[CELL_W-1:0];
            CSR_CELL_LOW_FAULT:  limits_ff.cell_low_fault  <= csr_write_data[CELL_W-1:0];
            CSR_TEMP_HIGH_FAULT: limits_ff.temp_high_fault <= csr_write_data[TEMP_W-1:0];
            CSR_IMBALANCE_FAULT: limits_ff.imbalance_fault <= csr_write_data[CELL_W-1:0];
            CSR_CELL_HIGH_WARN:  limits_ff.cell_high_warn  <= csr_write_data[CELL_W-1:0];
            CSR_CELL_LOW_WARN:   limits_ff.cell_low_warn   <= csr_write_data[CELL_W-1:0];
            default: ;
         endcase
      end
   end

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         item_valid_ff <= 1'b0;
      end else if (req_if.ready) begin
         item_valid_ff <= req_if.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         item_ff.operation      <= req_if.operation;
         item_ff.sample_value   <= req_if.sample_value;
         item_ff.balance_active <= req_if.balance_active;
      end
   end

   // sample conditioning
   assign volt_value = item_ff.sample_value[SAMPLE_W-1] ? '0
                                                        : item_ff.sample_value[CELL_W-1:0];

   always_comb begin
      if (item_ff.sample_value > TEMP_SAT_HIGH) begin
         temp_value = TEMP_SAT_HIGH[TEMP_W-1:0];
      end else if (item_ff.sample_value < TEMP_SAT_LOW) begin
         temp_value = TEMP_SAT_LOW[TEMP_W-1:0];
      end else begin
         temp_value = item_ff.sample_value[TEMP_W-1:0];
      end
   end

   assign sum_wide = {1'b0, scan_ff.volt_total} + {{(PACK_W+1-CELL_W){1'b0}}, volt_value};
   assign sum_sat  = sum_wide[PACK_W] ? '1 : sum_wide[PACK_W-1:0];

   // scan update
   always_comb begin
      scan_in = scan_ff;
      if (advance) begin
         unique case (op_type'(item_ff.operation))
            OP_VOLT: begin
               scan_in.volt_seen  = 1'b1;
               scan_in.volt_total = sum_sat;
               if (!scan_ff.volt_seen || volt_value > scan_ff.volt_high) begin
                  scan_in.volt_high = volt_value;
               end
               if (!scan_ff.volt_seen || volt_value < scan_ff.volt_low) begin
                  scan_in.volt_low = volt_value;
               end
            end
            OP_TEMP: begin
               scan_in.heat_seen = 1'b1;
               if (!scan_ff.heat_seen || temp_value > scan_ff.heat_high) begin
                  scan_in.heat_high = temp_value;
               end
               if (!scan_ff.heat_seen || temp_value < scan_ff.heat_low) begin
                  scan_in.heat_low = temp_value;
               end
            end
            OP_FINISH: begin
               scan_in = '0;
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         scan_ff <= '0;
      end else begin
         scan_ff <= scan_in;
      end
   end

   bcfm_eval u_eval (
      .scan          (scan_ff),
      .limits        (limits_ff),
      .fault_flags   (fault_flags),
      .warning_flags (warning_flags)
   );

   // response register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance && is_finish) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_if.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && is_finish) begin
         rsp_if.fault_flags   <= fault_flags;
         rsp_if.warning_flags <= warning_flags;
         rsp_if.state_flags   <= item_ff.balance_active ? BALANCE_FLAG : '0;
         rsp_if.pack_sum      <= scan_ff.volt_total;
         rsp_if.cell_max      <= scan_ff.volt_high;
         rsp_if.cell_min      <= scan_ff.volt_low;
         rsp_if.temp_max      <= scan_ff.heat_high;
         rsp_if.temp_min      <= scan_ff.heat_low;
      end
   end

   assign rsp_if.valid = rsp_valid_ff;

   // checks
   a_finish_clears: assert property (@(posedge clock) disable iff (reset)
      advance && is_finish |=> !scan_ff.volt_seen && !scan_ff.heat_seen &&
                               scan_ff.volt_total == '0)
      else $error("scan not cleared after finish");

   a_finish_responds: assert property (@(posedge clock) disable iff (reset)
      advance && is_finish |=> rsp_valid_ff)
      else $error("finish without response");

   a_unseen_zero: assert property (@(posedge clock) disable iff (reset)
      !scan_ff.volt_seen |-> scan_ff.volt_high == '0 && scan_ff.volt_low == '0 &&
                             scan_ff.volt_total == '0)
      else $error("voltage extremes not zero before first sample");

   a_order: assert property (@(posedge clock) disable iff (reset)
      scan_ff.volt_seen |-> scan_ff.volt_high >= scan_ff.volt_low)
      else $error("voltage extremes out of order");

   a_stall_only_on_finish: assert property (@(posedge clock) disable iff (reset)
      !req_if.ready |-> item_valid_ff && is_finish && rsp_valid_ff && !rsp_if.ready)
      else $error("request stalled without a blocked finish");

endmodule

FILE: dv/tb_battery_cell_fault_monitor_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Battery cell fault monitor testbench
// Drives cell voltage, temperature and finish transactions with random gaps
// and response stalls. A scoreboard class tracks the scan extremes and pack
// sum, predicts each finish summary and checks it field by field. Threshold
// registers are rewritten between phases while the block is idle.
// ----------------------------------------------------------------------------
module tb_battery_cell_fault_monitor_unit
   import bcfm_pkg::*;
;

   localparam int LIMIT_CYCLES = 1000000;
   localparam int DRAIN_CYCLES = 6;
   localparam int REPORT_LIMIT = 10;
   localparam int PHASES       = 7;
   localparam int PHASE_ITEMS  = 220;
   localparam logic [1:0] OP_UNUSED = 2'd3;

   typedef struct packed {
      logic [FLAG_W-1:0]        fault_flags;
      logic [FLAG_W-1:0]        warning_flags;
      logic [FLAG_W-1:0]        state_flags;
      logic [PACK_W-1:0]        pack_sum;
      logic [CELL_W-1:0]        cell_max;
      logic [CELL_W-1:0]        cell_min;
      logic signed [TEMP_W-1:0] temp_max;
      logic signed [TEMP_W-1:0] temp_min;
   } scan_summary_type;

   class scan_scoreboard;
      limits_type       limits;
      scan_state_type   scan;
      scan_summary_type pending[$];
      int mismatches;
      int summaries;
      int cell_samples;
      int temp_samples;
      int ignored;
      int saturated;
      int accepted;

      function void restore_defaults();
         limits.pack_high_fault = PACK_HIGH_FAULT_RST;
         limits.pack_low_fault  = PACK_LOW_FAULT_RST;
         limits.cell_high_fault = CELL_HIGH_FAULT_RST;
         limits.cell_low_fault  = CELL_LOW_FAULT_RST;
         limits.temp_high_fault = TEMP_HIGH_FAULT_RST;
         limits.imbalance_fault = IMBALANCE_FAULT_RST;
         limits.cell_high_warn  = CELL_HIGH_WARN_RST;
         limits.cell_low_warn   = CELL_LOW_WARN_RST;
         scan = '0;
      endfunction

      function void write_limit(csr_index_type idx, logic [CSR_W-1:0] data);
         case (idx)
            CSR_PACK_HIGH_FAULT: limits.pack_high_fault = data[PACK_W-1:0];
            CSR_PACK_LOW_FAULT:  limits.pack_low_fault  = data[PACK_W-1:0];
            CSR_CELL_HIGH_FAULT: limits.cell_high_fault = data[CELL_W-1:0];
            CSR_CELL_LOW_FAULT:  limits.cell_low_fault  = data[CELL_W-1:0];
            CSR_TEMP_HIGH_FAULT: limits.temp_high_fault = data[TEMP_W-1:0];
            CSR_IMBALANCE_FAULT: limits.imbalance_fault = data[CELL_W-1:0];
            CSR_CELL_HIGH_WARN:  limits.cell_high_warn  = data[CELL_W-1:0];
            CSR_CELL_LOW_WARN:   limits.cell_low_warn   = data[CELL_W-1:0];
            default: ;
         endcase
      endfunction

      function void note_request(logic [1:0] op, logic signed [SAMPLE_W-1:0] value,
                                 logic bal);
         logic [CELL_W-1:0]        volt;
         logic signed [TEMP_W-1:0] heat;
         logic [PACK_W:0]          total;
         logic [CELL_W-1:0]        spread;
         scan_summary_type         s;
         case (op)
            OP_VOLT: begin
               volt = (value < 0) ? '0 : value[CELL_W-1:0];
               if (!scan.volt_seen) begin
                  scan.volt_high = volt;
                  scan.volt_low  = volt;
                  scan.volt_seen = 1'b1;
               end else begin
                  if (volt > scan.volt_high) scan.volt_high = volt;
                  if (volt < scan.volt_low) scan.volt_low = volt;
               end
               total = {1'b0, scan.volt_total} + {{(PACK_W+1-CELL_W){1'b0}}, volt};
               scan.volt_total = total[PACK_W] ? '1 : total[PACK_W-1:0];
               cell_samples++;
               accepted++;
            end
            OP_TEMP: begin
               if (value > TEMP_SAT_HIGH) heat = TEMP_SAT_HIGH[TEMP_W-1:0];
               else if (value < TEMP_SAT_LOW) heat = TEMP_SAT_LOW[TEMP_W-1:0];
               else heat = value[TEMP_W-1:0];
               if (!scan.heat_seen) begin
                  scan.heat_high = heat;
                  scan.heat_low  = heat;
                  scan.heat_seen = 1'b1;
               end else begin
                  if (heat > $signed(scan.heat_high)) scan.heat_high = heat;
                  if (heat < $signed(scan.heat_low)) scan.heat_low = heat;
               end
               temp_samples++;
               accepted++;
            end
            OP_FINISH: begin
               spread = (scan.volt_high >= scan.volt_low) ?
                        scan.volt_high - scan.volt_low : '0;
               s = '0;
               s.fault_flags[FLAG_PACK_HIGH] = scan.volt_total >= limits.pack_high_fault;
               s.fault_flags[FLAG_PACK_LOW]  = scan.volt_total <= limits.pack_low_fault;
               s.fault_flags[FLAG_CELL_LOW]  = scan.volt_low <= limits.cell_low_fault;
               s.fault_flags[FLAG_CELL_HIGH] = scan.volt_high >= limits.cell_high_fault;
               s.fault_flags[FLAG_TEMP_HIGH] =
                  $signed(scan.heat_high) >= $signed(limits.temp_high_fault);
               s.fault_flags[FLAG_FAULT_IMB] = spread >= limits.imbalance_fault;
               s.warning_flags[FLAG_PACK_HIGH] = scan.volt_total >= PACK_HIGH_WARN;
               s.warning_flags[FLAG_PACK_LOW]  = scan.volt_total <= PACK_LOW_WARN;
               s.warning_flags[FLAG_CELL_LOW]  = scan.volt_low <= limits.cell_low_warn;
               s.warning_flags[FLAG_CELL_HIGH] = scan.volt_high >= limits.cell_high_warn;
               s.warning_flags[FLAG_TEMP_HIGH] = $signed(scan.heat_high) >= TEMP_HIGH_WARN;
               s.warning_flags[FLAG_TEMP_LOW]  = $signed(scan.heat_low) <= TEMP_LOW_WARN;
               s.warning_flags[FLAG_WARN_IMB]  = spread >= IMBALANCE_WARN;
               s.state_flags = bal ? BALANCE_FLAG : '0;
               s.pack_sum = scan.volt_total;
               s.cell_max = scan.volt_high;
               s.cell_min = scan.volt_low;
               s.temp_max = scan.heat_high;
               s.temp_min = scan.heat_low;
               if (&scan.volt_total) saturated++;
               pending.push_back(s);
               scan = '0;
               accepted++;
            end
            default: ignored++;
         endcase
      endfunction

      function void compare_field(string field, logic signed [31:0] want,
                                  logic signed [31:0] got);
         if (got !== want) begin
            mismatches++;
            if (mismatches <= REPORT_LIMIT)
               $display("summary %0d %s: expected %0d, got %0d", summaries, field,
                        want, got);
         end
      endfunction

      function void check_summary(scan_summary_type got);
         scan_summary_type want;
         if (pending.size() == 0) begin
            mismatches++;
            if (mismatches <= REPORT_LIMIT)
               $display("summary transaction with none pending: fault %h pack %0d",
                        got.fault_flags, got.pack_sum);
            return;
         end
         want = pending.pop_front();
         summaries++;
         compare_field("fault_flags", 32'(want.fault_flags), 32'(got.fault_flags));
         compare_field("warning_flags", 32'(want.warning_flags),
                       32'(got.warning_flags));
         compare_field("state_flags", 32'(want.state_flags), 32'(got.state_flags));
         compare_field("pack_sum", 32'(want.pack_sum), 32'(got.pack_sum));
         compare_field("cell_max", 32'(want.cell_max), 32'(got.cell_max));
         compare_field("cell_min", 32'(want.cell_min), 32'(got.cell_min));
         compare_field("temp_max", 32'($signed(want.temp_max)),
                       32'($signed(got.temp_max)));
         compare_field("temp_min", 32'($signed(want.temp_min)),
                       32'($signed(got.temp_min)));
      endfunction
   endclass

   logic                 clock;
   logic                 reset;
   logic                 csr_write_enable;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [CSR_W-1:0]     csr_write_data;
   int                   cycle_count;
   int                   req_quiet;
   int                   rsp_quiet;

   scan_scoreboard board = new();

   bcfm_req_if req();
   bcfm_rsp_if rsp();

   battery_cell_fault_monitor_unit dut (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .req_if           (req),
      .rsp_if           (rsp)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= LIMIT_CYCLES) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("end of test: mismatches");
         $finish;
      end
   end

   // mostly random waits, with occasional runs of back-to-back transactions
   function automatic int draw_wait(inout int quiet_left);
      if (quiet_left > 0) begin
         quiet_left--;
         return 0;
      end
      if ($urandom_range(0, 15) == 0) begin
         quiet_left = $urandom_range(10, 40);
         return 0;
      end
      return $urandom_range(0, 17);
   endfunction

   function automatic logic signed [SAMPLE_W-1:0] pick_volt(bit high_only);
      int r;
      r = $urandom_range(0, 9);
      if (high_only) return SAMPLE_W'($urandom_range(60000, 65535));
      if (r < 8) return SAMPLE_W'($urandom_range(25000, 46000));
      if (r == 8) return SAMPLE_W'($urandom_range(0, 65535));
      return SAMPLE_W'($urandom);
   endfunction

   function automatic logic signed [SAMPLE_W-1:0] pick_temp();
      if ($urandom_range(0, 9) < 8)
         return SAMPLE_W'($signed($urandom_range(0, 130)) - 40);
      return SAMPLE_W'($urandom);
   endfunction

   task automatic send_item(logic [1:0] op, logic signed [SAMPLE_W-1:0] value,
                            logic bal);
      int gap;
      gap = draw_wait(req_quiet);
      if (gap > 0) begin
         req.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req.valid          <= 1'b1;
      req.operation      <= op;
      req.sample_value   <= value;
      req.balance_active <= bal;
      do @(posedge clock); while (!req.ready);
      board.note_request(op, value, bal);
   endtask

   task automatic settle_idle();
      req.valid <= 1'b0;
      while (board.pending.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_limit(csr_index_type idx, logic [CSR_W-1:0] data);
      csr_write_enable <= 1'b1;
      csr_index        <= idx;
      csr_write_data   <= data;
      @(posedge clock);
      board.write_limit(idx, data);
   endtask

   task automatic apply_limits(int phase);
      logic [CSR_W-1:0] lim [8];
      case (phase)
         0: foreach (lim[i]) lim[i] = '0;
         1: begin
            lim[CSR_PACK_HIGH_FAULT] = 23'h7FFFFF;
            lim[CSR_PACK_LOW_FAULT]  = 23'h7FFFFF;
            lim[CSR_CELL_HIGH_FAULT] = 23'hFFFF;
            lim[CSR_CELL_LOW_FAULT]  = 23'hFFFF;
            lim[CSR_TEMP_HIGH_FAULT] = 23'h7F;
            lim[CSR_IMBALANCE_FAULT] = 23'hFFFF;
            lim[CSR_CELL_HIGH_WARN]  = 23'hFFFF;
            lim[CSR_CELL_LOW_WARN]   = 23'hFFFF;
         end
         2: begin
            lim[CSR_PACK_HIGH_FAULT] = '0;
            lim[CSR_PACK_LOW_FAULT]  = 23'h7FFFFF;
            lim[CSR_CELL_HIGH_FAULT] = '0;
            lim[CSR_CELL_LOW_FAULT]  = 23'hFFFF;
            lim[CSR_TEMP_HIGH_FAULT] = 23'h80;
            lim[CSR_IMBALANCE_FAULT] = '0;
            lim[CSR_CELL_HIGH_WARN]  = '0;
            lim[CSR_CELL_LOW_WARN]   = 23'hFFFF;
         end
         default: begin
            lim[CSR_PACK_HIGH_FAULT] = CSR_W'($urandom_range(300000, 450000));
            lim[CSR_PACK_LOW_FAULT]  = CSR_W'($urandom_range(200000, 350000));
            lim[CSR_CELL_HIGH_FAULT] = CSR_W'($urandom_range(38000, 46000));
            lim[CSR_CELL_LOW_FAULT]  = CSR_W'($urandom_range(26000, 34000));
            lim[CSR_TEMP_HIGH_FAULT] = CSR_W'(8'($signed($urandom_range(0, 100)) - 20));
            lim[CSR_IMBALANCE_FAULT] = CSR_W'($urandom_range(0, 12000));
            lim[CSR_CELL_HIGH_WARN]  = CSR_W'($urandom_range(36000, 46000));
            lim[CSR_CELL_LOW_WARN]   = CSR_W'($urandom_range(28000, 36000));
         end
      endcase
      foreach (lim[i]) write_limit(csr_index_type'(i), lim[i]);
      csr_write_enable <= 1'b0;
   endtask

   task automatic run_directed();
      send_item(OP_FINISH, '0, 1'b0);
      send_item(OP_VOLT, 17'sd0, 1'b0);
      send_item(OP_VOLT, 17'sh0FFFF, 1'b1);
      send_item(OP_VOLT, -17'sd1, 1'b0);
      send_item(OP_VOLT, 17'sh10000, 1'b1);
      send_item(OP_TEMP, 17'sd127, 1'b0);
      send_item(OP_TEMP, 17'sd200, 1'b0);
      send_item(OP_TEMP, -17'sd128, 1'b1);
      send_item(OP_TEMP, -17'sd300, 1'b0);
      send_item(OP_FINISH, 17'sh1FFFF, 1'b1);
      send_item(OP_UNUSED, 17'sh1FFFF, 1'b1);
      send_item(OP_TEMP, -17'sd5, 1'b0);
      send_item(OP_TEMP, 17'sd70, 1'b0);
      send_item(OP_FINISH, '0, 1'b0);
      send_item(OP_VOLT, 17'sd43000, 1'b0);
      send_item(OP_VOLT, 17'sd30000, 1'b0);
      send_item(OP_TEMP, 17'sd60, 1'b0);
      send_item(OP_FINISH, '0, 1'b1);
      send_item(OP_VOLT, 17'sd36000, 1'b0);
      send_item(OP_VOLT, 17'sd37000, 1'b0);
      send_item(OP_FINISH, '0, 1'b0);
   endtask

   // one scan: cells and temperatures interleaved, stray transactions, then finish
   task automatic run_scan();
      int  cells;
      int  temps;
      bit  long_scan;
      long_scan = ($urandom_range(0, 39) == 0);
      if (long_scan) cells = $urandom_range(129, 140);
      else if ($urandom_range(0, 19) == 0) cells = 0;
      else cells = $urandom_range(1, 12);
      temps = $urandom_range(0, 4);
      while (cells + temps > 0) begin
         if (cells > 0 && (temps == 0 || $urandom_range(0, 2) != 0)) begin
            send_item(OP_VOLT, pick_volt(long_scan), 1'($urandom_range(0, 1)));
            cells--;
         end else begin
            send_item(OP_TEMP, pick_temp(), 1'($urandom_range(0, 1)));
            temps--;
         end
         if ($urandom_range(0, 49) == 0)
            send_item(OP_UNUSED, SAMPLE_W'($urandom), 1'($urandom_range(0, 1)));
      end
      send_item(OP_FINISH, SAMPLE_W'($urandom), 1'($urandom_range(0, 1)));
   endtask

   initial begin
      scan_summary_type got;
      int stall;
      rsp.ready <= 1'b0;
      @(posedge clock);
      forever begin
         stall = draw_wait(rsp_quiet);
         if (stall > 0) begin
            rsp.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp.ready <= 1'b1;
         do @(posedge clock); while (!rsp.valid);
         got.fault_flags   = rsp.fault_flags;
         got.warning_flags = rsp.warning_flags;
         got.state_flags   = rsp.state_flags;
         got.pack_sum      = rsp.pack_sum;
         got.cell_max      = rsp.cell_max;
         got.cell_min      = rsp.cell_min;
         got.temp_max      = rsp.temp_max;
         got.temp_min      = rsp.temp_min;
         board.check_summary(got);
      end
   end

   initial begin
      int target;
      req_quiet          = 0;
      rsp_quiet          = 0;
      reset              <= 1'b1;
      csr_write_enable   <= 1'b0;
      csr_index          <= '0;
      csr_write_data     <= '0;
      req.valid          <= 1'b0;
      req.operation      <= '0;
      req.sample_value   <= '0;
      req.balance_active <= 1'b0;
      board.restore_defaults();
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      run_directed();
      for (int phase = 0; phase < PHASES; phase++) begin
         settle_idle();
         apply_limits(phase);
         target = board.accepted + PHASE_ITEMS;
         while (board.accepted < target) run_scan();
      end
      settle_idle();

      $display("checked %0d scan summaries (%0d with saturated pack sum) over %0d threshold sets",
               board.summaries, board.saturated, PHASES + 1);
      $display("sent %0d cell and %0d temperature samples, %0d unused-op transactions",
               board.cell_samples, board.temp_samples, board.ignored);
      if (board.mismatches == 0 && board.pending.size() == 0) begin
         $display("end of test: clean");
      end else begin
         $display("%0d mismatches, %0d summaries outstanding", board.mismatches,
                  board.pending.size());
         $display("end of test: mismatches");
      end
      $finish;
   end

endmodule
